@@ rtl/core/rbvi_pkg.sv @@
package rbvi_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Gravity scale 0.034 in Q16.16, rounded to nearest.
  localparam logic [11:0] GRAV_K = 12'((34 * 65536 + 500) / 1000);
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic signed [63:0] WMAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] WMIN64 = -64'sh0000_0000_8000_0000;

  // Input opcodes.
  localparam logic [2:0] OPC_TICK      = 3'd0;
  localparam logic [2:0] OPC_FORCE     = 3'd1;
  localparam logic [2:0] OPC_IMPULSE   = 3'd2;
  localparam logic [2:0] OPC_CLR_ACC   = 3'd3;
  localparam logic [2:0] OPC_CLR_VEL   = 3'd4;

  // Register indexes.
  localparam logic [2:0] REG_DRAG      = 3'd0;
  localparam logic [2:0] REG_MASS      = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED = 3'd2;
  localparam logic [2:0] REG_MAX_FALL  = 3'd3;
  localparam logic [2:0] REG_GRAVITY   = 3'd4;
  localparam logic [2:0] REG_GRAV_ON   = 3'd5;

  // Datapath micro-operations.
  localparam logic [4:0] DP_NOP        = 5'd0;
  localparam logic [4:0] DP_LOAD       = 5'd1;
  localparam logic [4:0] DP_CLR_ACC    = 5'd2;
  localparam logic [4:0] DP_CLR_VEL    = 5'd3;
  localparam logic [4:0] DP_SQ_CLR     = 5'd4;
  localparam logic [4:0] DP_MUL_SQ_DIR = 5'd5;
  localparam logic [4:0] DP_MUL_SQ_VEL = 5'd6;
  localparam logic [4:0] DP_SQ_ACC     = 5'd7;
  localparam logic [4:0] DP_SQRT_GO    = 5'd8;
  localparam logic [4:0] DP_MUL_DIR_PW = 5'd9;
  localparam logic [4:0] DP_DIV_PROD   = 5'd10;
  localparam logic [4:0] DP_DIV_MASS   = 5'd11;
  localparam logic [4:0] DP_ADD_ACC    = 5'd12;
  localparam logic [4:0] DP_ADD_VEL    = 5'd13;
  localparam logic [4:0] DP_FALL_ZERO  = 5'd14;
  localparam logic [4:0] DP_MUL_GRAV   = 5'd15;
  localparam logic [4:0] DP_G_SCALE    = 5'd16;
  localparam logic [4:0] DP_MUL_G_DT   = 5'd17;
  localparam logic [4:0] DP_FALL_UPD   = 5'd18;
  localparam logic [4:0] DP_MUL_ACC_DT = 5'd19;
  localparam logic [4:0] DP_VEL_INT    = 5'd20;
  localparam logic [4:0] DP_MUL_DRAG   = 5'd21;
  localparam logic [4:0] DP_VEL_SHIFT  = 5'd22;
  localparam logic [4:0] DP_MUL_VMAX   = 5'd23;
  localparam logic [4:0] DP_VEL_DQ     = 5'd24;
  localparam logic [4:0] DP_EMIT       = 5'd25;

  typedef struct packed {
    logic [16:0] drag;
    logic [30:0] mass;
    logic [30:0] max_speed;
    logic [30:0] max_fall;
    logic [30:0] gravity;
    logic        gravity_on;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic len_zero;
    logic over_limit;
    logic ground;
    logic grav_on;
    logic out_busy;
  } status_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > WMAX64) r = 32'sh7FFF_FFFF;
    else if (x < WMIN64) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ rtl/core/rbvi_regs.sv @@
module rbvi_regs import rbvi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drag       <= 17'd6554;
      cfg.mass       <= 31'd65536;
      cfg.max_speed  <= 31'd1966080;
      cfg.max_fall   <= 31'd229376;
      cfg.gravity    <= 31'd642253;
      cfg.gravity_on <= 1'b1;
    end else if (wr) begin
      unique case (index)
        REG_DRAG:      cfg.drag       <= pwdata[16:0];
        REG_MASS:      cfg.mass       <= pwdata[30:0];
        REG_MAX_SPEED: cfg.max_speed  <= pwdata[30:0];
        REG_MAX_FALL:  cfg.max_fall   <= pwdata[30:0];
        REG_GRAVITY:   cfg.gravity    <= pwdata[30:0];
        REG_GRAV_ON:   cfg.gravity_on <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_DRAG:      prdata = {15'd0, cfg.drag};
      REG_MASS:      prdata = {1'b0, cfg.mass};
      REG_MAX_SPEED: prdata = {1'b0, cfg.max_speed};
      REG_MAX_FALL:  prdata = {1'b0, cfg.max_fall};
      REG_GRAVITY:   prdata = {1'b0, cfg.gravity};
      REG_GRAV_ON:   prdata = {31'd0, cfg.gravity_on};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/rbvi_ctrl.sv @@
module rbvi_ctrl import rbvi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_SQ_CLR   = 5'd2;
  localparam logic [4:0] S_SQ_MUL   = 5'd3;
  localparam logic [4:0] S_SQ_ACC   = 5'd4;
  localparam logic [4:0] S_SQRT_GO  = 5'd5;
  localparam logic [4:0] S_SQRT_W   = 5'd6;
  localparam logic [4:0] S_AP_CHK   = 5'd7;
  localparam logic [4:0] S_AP_MUL   = 5'd8;
  localparam logic [4:0] S_AP_DIV1  = 5'd9;
  localparam logic [4:0] S_AP_W1    = 5'd10;
  localparam logic [4:0] S_AP_DIV2  = 5'd11;
  localparam logic [4:0] S_AP_W2    = 5'd12;
  localparam logic [4:0] S_AP_ADD   = 5'd13;
  localparam logic [4:0] S_GRAV     = 5'd14;
  localparam logic [4:0] S_G1       = 5'd15;
  localparam logic [4:0] S_G2       = 5'd16;
  localparam logic [4:0] S_G3       = 5'd17;
  localparam logic [4:0] S_VI_MUL   = 5'd18;
  localparam logic [4:0] S_VI_ADD   = 5'd19;
  localparam logic [4:0] S_DR_MUL   = 5'd20;
  localparam logic [4:0] S_DR_SET   = 5'd21;
  localparam logic [4:0] S_LIM_CHK  = 5'd22;
  localparam logic [4:0] S_LM_MUL   = 5'd23;
  localparam logic [4:0] S_LM_DIV   = 5'd24;
  localparam logic [4:0] S_LM_W     = 5'd25;
  localparam logic [4:0] S_LM_SET   = 5'd26;
  localparam logic [4:0] S_OUT      = 5'd27;

  logic [4:0] state, state_next;
  logic [1:0] idx, idx_next;
  logic [2:0] op_reg, op_reg_next;
  logic       last;

  assign last     = (idx == 2'd2);
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= 2'd0;
      op_reg <= OPC_TICK;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      op_reg <= op_reg_next;
    end
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    op_reg_next = op_reg;
    cmd.op      = DP_NOP;
    cmd.idx     = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = DP_LOAD;
          op_reg_next = opcode;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_reg)
          OPC_TICK:    state_next = S_GRAV;
          OPC_FORCE,
          OPC_IMPULSE: state_next = S_SQ_CLR;
          OPC_CLR_ACC: begin
            cmd.op     = DP_CLR_ACC;
            state_next = S_IDLE;
          end
          OPC_CLR_VEL: begin
            cmd.op     = DP_CLR_VEL;
            state_next = S_IDLE;
          end
          default:     state_next = S_IDLE;
        endcase
      end
      S_SQ_CLR: begin
        cmd.op     = DP_SQ_CLR;
        idx_next   = 2'd0;
        state_next = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.op     = (op_reg == OPC_TICK) ? DP_MUL_SQ_VEL : DP_MUL_SQ_DIR;
        state_next = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.op     = DP_SQ_ACC;
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? S_SQRT_GO : S_SQ_MUL;
      end
      S_SQRT_GO: begin
        cmd.op     = DP_SQRT_GO;
        state_next = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (status.sqrt_done) begin
          state_next = (op_reg == OPC_TICK) ? S_LIM_CHK : S_AP_CHK;
        end
      end
      S_AP_CHK: begin
        idx_next   = 2'd0;
        state_next = status.len_zero ? S_IDLE : S_AP_MUL;
      end
      S_AP_MUL: begin
        cmd.op     = DP_MUL_DIR_PW;
        state_next = S_AP_DIV1;
      end
      S_AP_DIV1: begin
        cmd.op     = DP_DIV_PROD;
        state_next = S_AP_W1;
      end
      S_AP_W1: begin
        if (status.div_done) state_next = S_AP_DIV2;
      end
      S_AP_DIV2: begin
        cmd.op     = DP_DIV_MASS;
        state_next = S_AP_W2;
      end
      S_AP_W2: begin
        if (status.div_done) state_next = S_AP_ADD;
      end
      S_AP_ADD: begin
        cmd.op     = (op_reg == OPC_FORCE) ? DP_ADD_ACC : DP_ADD_VEL;
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? S_IDLE : S_AP_MUL;
      end
      S_GRAV: begin
        idx_next = 2'd0;
        if (status.ground) begin
          cmd.op     = DP_FALL_ZERO;
          state_next = S_VI_MUL;
        end else if (status.grav_on) begin
          cmd.op     = DP_MUL_GRAV;
          state_next = S_G1;
        end else begin
          state_next = S_VI_MUL;
        end
      end
      S_G1: begin
        cmd.op     = DP_G_SCALE;
        state_next = S_G2;
      end
      S_G2: begin
        cmd.op     = DP_MUL_G_DT;
        state_next = S_G3;
      end
      S_G3: begin
        cmd.op     = DP_FALL_UPD;
        state_next = S_VI_MUL;
      end
      S_VI_MUL: begin
        cmd.op     = DP_MUL_ACC_DT;
        state_next = S_VI_ADD;
      end
      S_VI_ADD: begin
        cmd.op     = DP_VEL_INT;
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? S_DR_MUL : S_VI_MUL;
      end
      S_DR_MUL: begin
        cmd.op     = DP_MUL_DRAG;
        state_next = S_DR_SET;
      end
      S_DR_SET: begin
        cmd.op     = DP_VEL_SHIFT;
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? S_SQ_CLR : S_DR_MUL;
      end
      S_LIM_CHK: begin
        idx_next   = 2'd0;
        state_next = status.over_limit ? S_LM_MUL : S_OUT;
      end
      S_LM_MUL: begin
        cmd.op     = DP_MUL_VMAX;
        state_next = S_LM_DIV;
      end
      S_LM_DIV: begin
        cmd.op     = DP_DIV_PROD;
        state_next = S_LM_W;
      end
      S_LM_W: begin
        if (status.div_done) state_next = S_LM_SET;
      end
      S_LM_SET: begin
        cmd.op     = DP_VEL_DQ;
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? S_OUT : S_LM_MUL;
      end
      S_OUT: begin
        // The result word waits here until the output register is free.
        if (!status.out_busy) begin
          cmd.op     = DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/rbvi_datapath.sv @@
module rbvi_datapath import rbvi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  output status_t            status,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] power,
  input  logic [16:0]        time_step,
  input  logic               on_ground,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] step_x,
  output logic signed [31:0] step_y,
  output logic signed [31:0] step_z,
  output logic               moving
);

  logic signed [31:0] vel [3];
  logic signed [31:0] acc [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] fall;
  logic signed [31:0] pw;
  logic [16:0]        dt;
  logic               gnd;

  logic signed [63:0] prod;
  logic [63:0]        sum;
  logic signed [31:0] tq;
  logic signed [31:0] dq;
  logic [31:0]        len;

  // Shared divider state.
  logic        div_busy, div_done, div_neg;
  logic [63:0] div_dd;
  logic [31:0] div_rem, div_dvs;
  logic [6:0]  div_cnt;

  // Shared square root state.
  logic        sq_busy, sq_done;
  logic [63:0] sq_n, sq_r, sq_bit;

  logic signed [31:0] vel_i, acc_i, dir_i;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] prod_sh;
  logic signed [31:0] prod_q;
  logic [16:0]        drag_f;
  logic [31:0]        mass_d;
  logic [32:0]        div_trial;
  logic [63:0]        sq_rb;
  logic signed [33:0] fall_f, fall_lim;
  logic signed [31:0] sy;

  function automatic logic signed [31:0] pick(input logic signed [31:0] a0,
                                              input logic signed [31:0] a1,
                                              input logic signed [31:0] a2,
                                              input logic [1:0] i);
    logic signed [31:0] r;
    unique case (i)
      2'd0:    r = a0;
      2'd1:    r = a1;
      default: r = a2;
    endcase
    return r;
  endfunction

  assign vel_i = pick(vel[0], vel[1], vel[2], cmd.idx);
  assign acc_i = pick(acc[0], acc[1], acc[2], cmd.idx);
  assign dir_i = pick(dir[0], dir[1], dir[2], cmd.idx);

  // A drag of one or more gives a zero factor, which zeroes the velocity.
  assign drag_f = cfg.drag[16] ? 17'd0 : ONE_Q16 - cfg.drag;
  assign mass_d = (cfg.mass == 31'd0) ? 32'd1 : {1'b0, cfg.mass};

  always_comb begin
    unique case (cmd.op)
      DP_MUL_SQ_DIR: begin mul_a = 33'(dir_i);  mul_b = 33'(dir_i); end
      DP_MUL_SQ_VEL: begin mul_a = 33'(vel_i);  mul_b = 33'(vel_i); end
      DP_MUL_DIR_PW: begin mul_a = 33'(dir_i);  mul_b = 33'(pw); end
      DP_MUL_GRAV:   begin
        mul_a = {2'b00, cfg.gravity};
        mul_b = {21'd0, GRAV_K};
      end
      DP_MUL_G_DT:   begin mul_a = 33'(tq);     mul_b = {16'd0, dt}; end
      DP_MUL_ACC_DT: begin mul_a = 33'(acc_i);  mul_b = {16'd0, dt}; end
      DP_MUL_DRAG:   begin mul_a = 33'(vel_i);  mul_b = {16'd0, drag_f}; end
      DP_MUL_VMAX:   begin mul_a = 33'(vel_i);  mul_b = {2'b00, cfg.max_speed}; end
      default:       begin mul_a = 33'sd0;      mul_b = 33'sd0; end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign prod_sh = prod >>> FRAC_BITS;
  assign prod_q  = sat64(prod_sh);

  assign div_trial = {div_rem, div_dd[63]};
  assign sq_rb     = sq_r + sq_bit;

  assign fall_lim = {3'b000, cfg.max_fall};
  assign fall_f   = 34'(fall) - 34'(prod_q);
  assign sy       = sat33(33'(vel[1]) + 33'(fall));

  assign status.sqrt_done  = sq_done;
  assign status.div_done   = div_done;
  assign status.len_zero   = (len == 32'd0);
  assign status.over_limit = (len > {1'b0, cfg.max_speed});
  assign status.ground     = gnd;
  assign status.grav_on    = cfg.gravity_on;
  assign status.out_busy   = out_valid && !out_ready;

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        vel[k] <= 32'sd0;
        acc[k] <= 32'sd0;
      end
      fall <= 32'sd0;
    end else begin
      unique case (cmd.op)
        DP_CLR_ACC: for (int k = 0; k < 3; k++) acc[k] <= 32'sd0;
        DP_CLR_VEL: for (int k = 0; k < 3; k++) vel[k] <= 32'sd0;
        DP_ADD_ACC: acc[cmd.idx] <= sat33(33'(acc_i) + 33'(dq));
        DP_ADD_VEL: vel[cmd.idx] <= sat33(33'(vel_i) + 33'(dq));
        DP_FALL_ZERO: fall <= 32'sd0;
        DP_FALL_UPD: begin
          if (fall_f > fall_lim) fall <= fall_lim[31:0];
          else if (fall_f < -fall_lim) fall <= 32'(-fall_lim);
          else fall <= fall_f[31:0];
        end
        DP_VEL_INT:   vel[cmd.idx] <= sat33(33'(vel_i) + 33'(prod_q));
        DP_VEL_SHIFT: vel[cmd.idx] <= prod_q;
        DP_VEL_DQ:    vel[cmd.idx] <= dq;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      dir[0] <= dir_x;
      dir[1] <= dir_y;
      dir[2] <= dir_z;
      pw     <= power;
      dt     <= time_step;
      gnd    <= on_ground;
    end
    if (cmd.op == DP_MUL_SQ_DIR || cmd.op == DP_MUL_SQ_VEL ||
        cmd.op == DP_MUL_DIR_PW || cmd.op == DP_MUL_GRAV ||
        cmd.op == DP_MUL_G_DT || cmd.op == DP_MUL_ACC_DT ||
        cmd.op == DP_MUL_DRAG || cmd.op == DP_MUL_VMAX) begin
      prod <= mul_p[63:0];
    end
    if (cmd.op == DP_SQ_CLR) sum <= 64'd0;
    else if (cmd.op == DP_SQ_ACC) sum <= sum + prod;
    if (cmd.op == DP_G_SCALE) tq <= prod_q;
  end

  // Restoring divider, one quotient bit per cycle, then a finish step that
  // applies the sign and saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.op == DP_DIV_PROD || cmd.op == DP_DIV_MASS) begin
        div_busy <= 1'b1;
        div_cnt  <= 7'd64;
        div_rem  <= 32'd0;
        if (cmd.op == DP_DIV_PROD) begin
          div_neg <= prod[63];
          div_dd  <= prod[63] ? 64'(-prod) : prod;
          div_dvs <= len;
        end else begin
          div_neg <= dq[31];
          div_dd  <= dq[31] ? {16'd0, 32'(-dq), 16'd0} : {16'd0, dq, 16'd0};
          div_dvs <= mass_d;
        end
      end else if (div_busy) begin
        if (div_cnt != 7'd0) begin
          div_cnt <= div_cnt - 7'd1;
          if (div_trial >= {1'b0, div_dvs}) begin
            div_rem <= 32'(div_trial - {1'b0, div_dvs});
            div_dd  <= {div_dd[62:0], 1'b1};
          end else begin
            div_rem <= div_trial[31:0];
            div_dd  <= {div_dd[62:0], 1'b0};
          end
        end else begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
          if (!div_neg) begin
            dq <= (div_dd > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_dd[31:0];
          end else begin
            dq <= (div_dd > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_dd[31:0]);
          end
        end
      end
    end
  end

  // Integer square root, two radicand bits per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.op == DP_SQRT_GO) begin
        sq_busy <= 1'b1;
        sq_n    <= sum;
        sq_r    <= 64'd0;
        sq_bit  <= 64'd1 << 62;
      end else if (sq_busy) begin
        if (sq_bit != 64'd0) begin
          if (sq_n >= sq_rb) begin
            sq_n <= sq_n - sq_rb;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end else begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
          len     <= sq_r[31:0];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      step_x <= vel[0];
      step_y <= sy;
      step_z <= vel[2];
      moving <= (vel[0] != 32'sd0) || (sy != 32'sd0) || (vel[2] != 32'sd0);
    end
  end

endmodule

@@ rtl/core/rigid_body_velocity_integrator_top.sv @@
// Velocity integrator for one rigid body in signed Q16.16. Opcode 0 is a tick
// and returns one step word; force, impulse and the two clear opcodes return
// nothing. Items are taken one at a time. A force or impulse uses the shared
// 64-step divider for two divisions per axis, after the square root of the
// squared direction length. A force or impulse with a zero direction stops
// after the square root. A tick uses one division per axis only when the
// speed limit applies.
// The output register lets the next item start while a step word waits.
module rigid_body_velocity_integrator_top import rbvi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] power,
  input  logic [16:0]        time_step,
  input  logic               on_ground,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] step_x,
  output logic signed [31:0] step_y,
  output logic signed [31:0] step_z,
  output logic               moving,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  rbvi_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  rbvi_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .opcode, .status, .cmd
  );

  rbvi_datapath u_dp (
    .clk, .rst, .cmd, .cfg, .status,
    .dir_x, .dir_y, .dir_z, .power, .time_step, .on_ground,
    .out_valid, .out_ready, .step_x, .step_y, .step_z, .moving
  );

endmodule
